[src/rcst_pkg.sv]
// Package for the range clamp segment tree: item structs and op codes.
// No dependencies; imported by every module of the block but rcst_ram.
package rcst_pkg;

  localparam logic [1:0] OP_RAISE = 2'd0;
  localparam logic [1:0] OP_LOWER = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam int CFG_BITS = 11;
  localparam logic [CFG_BITS-1:0] WALL_RESET = 11'd1024;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  range_first;
    logic [9:0]  range_last;
    logic [15:0] height;
    logic [9:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [15:0] height_value;
    logic        out_of_range;
  } out_item_t;

endpackage

[src/rcst_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module rcst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/range_clamp_segment_tree.sv]
// Range clamp segment tree: top level, tree walker and node memory.
// Depends on rcst_pkg and rcst_ram.
//
// Keeps MAX_POSITIONS heights, all zero after reset, as a lazy segment tree of
// clamp pairs (low, high) in one node RAM of 4*MAX_POSITIONS words. After reset
// a clearing pass writes every node with in_ready_o low (configuration writes
// are still taken). A raise or lower item walks the tree depth first; every
// split node reads both children, writes both children and writes itself back
// to identity, while a covered or disjoint node is settled in one visit. The
// number S of split nodes is at most 2*log2(MAX_POSITIONS) - 1, and they leave
// S + 1 covered or disjoint visits. A read walks one root-to-leaf path, reading
// and writing both children at each level, until its result is posted. Empty
// updates and op 3 end at accept, and an out-of-range read goes straight to
// posting its result. Items are worked one at a time; the result sits in an
// output register, so the next item is accepted while it waits to be taken.
module range_clamp_segment_tree import rcst_pkg::*; #(
  parameter int MAX_POSITIONS = 1024,
  parameter int HEIGHT_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_BITS-1:0] cfg_data_i
);

  localparam int HB    = HEIGHT_BITS;
  localparam int NODES = 4 * MAX_POSITIONS;
  localparam int NW    = $clog2(NODES);
  localparam int PW    = $clog2(MAX_POSITIONS);
  localparam int SD    = $clog2(MAX_POSITIONS) + 1;   // pending right children
  localparam int SIW   = $clog2(SD);
  localparam int SPW   = $clog2(SD + 1);
  localparam logic [HB-1:0] ONES = {HB{1'b1}};

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_ROOT  = 9'b000000100,
    ST_VISIT = 9'b000001000,
    ST_RDR   = 9'b000010000,
    ST_WL    = 9'b000100000,
    ST_WR    = 9'b001000000,
    ST_WP    = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_e;

  // node word: {high, low}
  function automatic logic [2*HB-1:0] push_f(input logic [2*HB-1:0] c,
                                             input logic [2*HB-1:0] p);
    logic [HB-1:0] ch, cl, ph, pl, hi, lo;
    ch = c[2*HB-1:HB];
    cl = c[HB-1:0];
    ph = p[2*HB-1:HB];
    pl = p[HB-1:0];
    hi = (ch < ph) ? ch : ph;
    hi = (hi > pl) ? hi : pl;
    lo = (cl > pl) ? cl : pl;
    lo = (lo < ph) ? lo : ph;
    return {hi, lo};
  endfunction

  state_e                 state_q, state_d;
  logic [NW-1:0]          clr_q, clr_d;
  logic [CFG_BITS-1:0]    wall_q;
  logic                   raise_q, raise_d;
  logic                   rd_q, rd_d;
  logic [PW-1:0]          ql_q, ql_d, qr_q, qr_d, x_q, x_d;
  logic [HB-1:0]          h_q, h_d;
  logic [NW-1:0]          node_q, node_d;
  logic [PW-1:0]          nl_q, nl_d, nr_q, nr_d;
  logic [2*HB-1:0]        cur_q, cur_d, lval_q, lval_d;
  logic [2*HB-1:0]        pl_q, pl_d, pr_q, pr_d;
  out_item_t              res_q, res_d;
  logic [SPW-1:0]         sp_q, sp_d;
  logic                   out_valid_q;
  out_item_t              out_q;

  logic [NW-1:0]          stk_node_q [SD];
  logic [PW-1:0]          stk_nl_q   [SD];
  logic [PW-1:0]          stk_nr_q   [SD];
  logic [2*HB-1:0]        stk_val_q  [SD];
  logic                   push_en;

  logic                   we;
  logic [NW-1:0]          waddr, raddr;
  logic [2*HB-1:0]        wdata, rdata;

  // node geometry
  logic [PW-1:0]  mid;
  logic [NW-1:0]  lnode, rnode;
  logic           disj, cov, leaf;
  logic [SIW-1:0] sp_idx, top_idx;

  assign mid     = nl_q + ((nr_q - nl_q) >> 1);
  assign lnode   = {node_q[NW-2:0], 1'b0};
  assign rnode   = {node_q[NW-2:0], 1'b1};
  assign disj    = (nl_q > qr_q) || (nr_q < ql_q);
  assign cov     = (nl_q >= ql_q) && (nr_q <= qr_q);
  assign leaf    = (nl_q == nr_q);
  assign sp_idx  = sp_q[SIW-1:0];
  assign top_idx = sp_idx - SIW'(1);

  // accept-time decode
  logic        accept, out_free;
  logic [31:0] len32, first32, last32, pos32, h32, lastc32;
  logic        upd_empty, is_upd;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign len32    = (32'(wall_q) > 32'(MAX_POSITIONS)) ? 32'(MAX_POSITIONS) : 32'(wall_q);
  assign first32  = 32'(in_item_i.range_first);
  assign last32   = 32'(in_item_i.range_last);
  assign pos32    = 32'(in_item_i.position);
  assign h32      = 32'(in_item_i.height);
  assign lastc32  = (last32 > len32 - 32'd1) ? len32 - 32'd1 : last32;
  assign upd_empty = (first32 > last32) || (first32 >= len32);
  assign is_upd   = (in_item_i.op == OP_RAISE) || (in_item_i.op == OP_LOWER);

  // leaf value for reads
  logic [HB-1:0] leaf_v;
  logic [31:0]   leaf32;
  assign leaf_v = (cur_q[HB-1:0] < cur_q[2*HB-1:HB]) ? cur_q[HB-1:0] : cur_q[2*HB-1:HB];
  assign leaf32 = 32'(leaf_v);

  // clamp applied to a covered node
  logic [2*HB-1:0] applied;
  always_comb begin
    if (raise_q) begin
      applied[HB-1:0]    = (cur_q[HB-1:0] > h_q) ? cur_q[HB-1:0] : h_q;
      applied[2*HB-1:HB] = (cur_q[2*HB-1:HB] > h_q) ? cur_q[2*HB-1:HB] : h_q;
    end else begin
      applied[HB-1:0]    = (cur_q[HB-1:0] < h_q) ? cur_q[HB-1:0] : h_q;
      applied[2*HB-1:HB] = (cur_q[2*HB-1:HB] < h_q) ? cur_q[2*HB-1:HB] : h_q;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    raise_d = raise_q;
    rd_d    = rd_q;
    ql_d    = ql_q;
    qr_d    = qr_q;
    x_d     = x_q;
    h_d     = h_q;
    node_d  = node_q;
    nl_d    = nl_q;
    nr_d    = nr_q;
    cur_d   = cur_q;
    lval_d  = lval_q;
    pl_d    = pl_q;
    pr_d    = pr_q;
    res_d   = res_q;
    sp_d    = sp_q;
    push_en = 1'b0;
    we      = 1'b0;
    waddr   = node_q;
    wdata   = applied;
    raddr   = lnode;

    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + NW'(1);
        if (clr_q == NW'(NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        raddr = NW'(1);
        if (accept) begin
          raise_d = (in_item_i.op == OP_RAISE);
          rd_d    = (in_item_i.op == OP_READ);
          ql_d    = first32[PW-1:0];
          qr_d    = lastc32[PW-1:0];
          x_d     = pos32[PW-1:0];
          h_d     = h32[HB-1:0];
          node_d  = NW'(1);
          nl_d    = '0;
          nr_d    = PW'(MAX_POSITIONS - 1);
          sp_d    = '0;
          if (is_upd) begin
            if (!upd_empty) begin
              state_d = ST_ROOT;
            end
          end else if (in_item_i.op == OP_READ) begin
            if (pos32 >= len32) begin
              res_d.height_value = '0;
              res_d.out_of_range = 1'b1;
              state_d = ST_EMIT;
            end else begin
              state_d = ST_ROOT;
            end
          end
        end
      end
      ST_ROOT: begin
        cur_d   = rdata;
        state_d = ST_VISIT;
      end
      ST_VISIT: begin
        if (rd_q) begin
          if (leaf) begin
            res_d.height_value = leaf32[15:0];
            res_d.out_of_range = 1'b0;
            state_d = ST_EMIT;
          end else begin
            raddr   = lnode;
            state_d = ST_RDR;
          end
        end else if (disj || cov) begin
          we = cov;
          waddr = node_q;
          wdata = applied;
          if (sp_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            node_d = stk_node_q[top_idx];
            nl_d   = stk_nl_q[top_idx];
            nr_d   = stk_nr_q[top_idx];
            cur_d  = stk_val_q[top_idx];
            sp_d   = sp_q - SPW'(1);
          end
        end else begin
          raddr   = lnode;
          state_d = ST_RDR;
        end
      end
      ST_RDR: begin
        raddr   = rnode;
        lval_d  = rdata;
        state_d = ST_WL;
      end
      ST_WL: begin
        pl_d    = push_f(lval_q, cur_q);
        pr_d    = push_f(rdata, cur_q);
        we      = 1'b1;
        waddr   = lnode;
        wdata   = push_f(lval_q, cur_q);
        state_d = ST_WR;
      end
      ST_WR: begin
        we    = 1'b1;
        waddr = rnode;
        wdata = pr_q;
        if (rd_q) begin
          if (x_q <= mid) begin
            node_d = lnode;
            nr_d   = mid;
            cur_d  = pl_q;
          end else begin
            node_d = rnode;
            nl_d   = mid + PW'(1);
            cur_d  = pr_q;
          end
          state_d = ST_VISIT;
        end else begin
          state_d = ST_WP;
        end
      end
      ST_WP: begin
        // split node back to identity; right child waits on the stack
        we      = 1'b1;
        waddr   = node_q;
        wdata   = {ONES, {HB{1'b0}}};
        push_en = 1'b1;
        sp_d    = sp_q + SPW'(1);
        node_d  = lnode;
        nr_d    = mid;
        cur_d   = pl_q;
        state_d = ST_VISIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      wall_q      <= WALL_RESET;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sp_q    <= sp_d;
      if (cfg_valid_i) begin
        wall_q <= cfg_data_i;
      end
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raise_d_hold: begin
      raise_q <= raise_d;
      rd_q    <= rd_d;
      ql_q    <= ql_d;
      qr_q    <= qr_d;
      x_q     <= x_d;
      h_q     <= h_d;
      node_q  <= node_d;
      nl_q    <= nl_d;
      nr_q    <= nr_d;
      cur_q   <= cur_d;
      lval_q  <= lval_d;
      pl_q    <= pl_d;
      pr_q    <= pr_d;
      res_q   <= res_d;
    end
    if (state_q == ST_EMIT && out_free) begin
      out_q <= res_q;
    end
    if (push_en) begin
      stk_node_q[sp_idx] <= rnode;
      stk_nl_q[sp_idx]   <= mid + PW'(1);
      stk_nr_q[sp_idx]   <= nr_q;
      stk_val_q[sp_idx]  <= pr_q;
    end
  end

  rcst_ram #(
    .WIDTH (2 * HB),
    .DEPTH (NODES)
  ) u_nodes (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[src/rcst_checker.sv]
// Port-level checker for range_clamp_segment_tree, bound to the top level.
// Depends on rcst_pkg.
module rcst_checker import rcst_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // out-of-range reads carry a zero height
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.out_of_range |-> out_item_o.height_value == 16'd0)
    else $error("out-of-range read with nonzero height");

  // a fresh result is posted only as the walker returns to idle
  a_rose_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result posted while walker busy");

endmodule

bind range_clamp_segment_tree rcst_checker u_rcst_checker (.*);

[sim/rcst_checker.sv]
// Checker for the range clamp segment tree: watches the item, result and
// register channels, predicts each read result and compares. Depends on rcst_pkg.
module rcst_scoreboard import rcst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_item_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  localparam int CAPACITY = 1024;

  // Lazy clamps compose exactly, so the tree collapses to a plain height array.
  logic [15:0]         wall_heights [CAPACITY];
  logic [CFG_BITS-1:0] wall_len;
  out_item_t           read_queue [$];

  assign pending_o = read_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned len, lo, hi;
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) wall_heights[i] = '0;
      wall_len = WALL_RESET;
      read_queue.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (read_queue.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result: height %0d oor %0b",
                     out_item_i.height_value, out_item_i.out_of_range);
        end else begin
          want = read_queue.pop_front();
          if (want.height_value !== out_item_i.height_value ||
              want.out_of_range !== out_item_i.out_of_range) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected height %0d oor %0b, got height %0d oor %0b",
                       want.height_value, want.out_of_range,
                       out_item_i.height_value, out_item_i.out_of_range);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        len = (wall_len > CAPACITY) ? CAPACITY : wall_len;
        lo  = in_item_i.range_first;
        hi  = in_item_i.range_last;
        case (in_item_i.op)
          OP_RAISE, OP_LOWER: begin
            if (lo <= hi && lo < len) begin
              if (hi > len - 1) hi = len - 1;
              for (int unsigned p = lo; p <= hi; p++) begin
                if (in_item_i.op == OP_RAISE) begin
                  if (in_item_i.height > wall_heights[p]) wall_heights[p] = in_item_i.height;
                end else begin
                  if (in_item_i.height < wall_heights[p]) wall_heights[p] = in_item_i.height;
                end
              end
            end
          end
          OP_READ: begin
            if (in_item_i.position >= len) begin
              want.height_value = '0;
              want.out_of_range = 1'b1;
            end else begin
              want.height_value = wall_heights[in_item_i.position];
              want.out_of_range = 1'b0;
            end
            read_queue = {read_queue, want};
          end
          default: ;
        endcase
      end
      if (cfg_valid_i && cfg_ready_i) wall_len = cfg_data_i;
    end
  end
endmodule

[sim/range_clamp_segment_tree_tb.sv]
// Testbench top for the range clamp segment tree: clock, reset, stimulus and verdict.
// Depends on rcst_pkg, rcst_scoreboard and the block itself.
module range_clamp_segment_tree_tb;
  import rcst_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_item_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_BITS-1:0] cfg_data_i;

  int fail_count;
  int pending_reads;

  // sender bookkeeping
  int burst_left;
  bit offering;
  // receiver long hold-off request, raised by the stimulus process
  bit hold_req;

  range_clamp_segment_tree dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  rcst_scoreboard checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_reads)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Offer one item starting at a falling edge; return at a falling edge.
  // Valid stays high into the next item unless the burst is used up.
  task automatic send_item(input in_item_t it);
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    offering   = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      offering   = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic stop_sending();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering   = 1'b0;
    end
  endtask

  // Drain every read, then give a worst-case update time to finish.
  task automatic drain();
    stop_sending();
    @(posedge clk_i);
    while (pending_reads != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_length(input logic [CFG_BITS-1:0] len);
    cfg_data_i  <= len;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_item_t make_item(input logic [1:0] op, input int first,
                                         input int last, input int h, input int pos);
    in_item_t it;
    it.op          = op;
    it.range_first = first[9:0];
    it.range_last  = last[9:0];
    it.height      = h[15:0];
    it.position    = pos[9:0];
    return it;
  endfunction

  // Mostly short well-formed updates and reads near the live length; some noise.
  function automatic in_item_t rand_item(input int len);
    in_item_t it;
    int pick, span, first;
    it   = in_item_t'(48'({$urandom, $urandom}));
    pick = $urandom_range(0, 99);
    span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
    first = (len > 0) ? $urandom_range(0, len - 1) : $urandom_range(0, 1023);
    if (pick < 40) begin
      it.op = OP_READ;
      if ($urandom_range(0, 9) != 0 && len > 0) it.position = $urandom_range(0, len - 1);
    end else if (pick < 90) begin
      it.op = (pick < 65) ? OP_RAISE : OP_LOWER;
      if (pick % 10 != 0) begin
        it.range_first = first[9:0];
        it.range_last  = (first + span > 1023) ? 10'd1023 : 10'(first + span);
      end
    end else if (pick < 95) begin
      it.op = 2'd3;
    end
    return it;
  endfunction

  // Receiver: ready follows a randomly chosen pattern of four; a long hold-off on request.
  initial begin
    int hold_cnt, mode, tick;
    hold_cnt = 0; mode = 0; tick = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 3000;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= $urandom_range(0, 1);
          2:       out_ready_i <= ($urandom_range(0, 7) == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    logic [CFG_BITS-1:0] lengths [6];
    int cur_len;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    hold_req    = 1'b0;
    offering    = 1'b0;
    burst_left  = $urandom_range(1, 40);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, every op, empty and long ranges, unused op
    send_item(make_item(OP_READ, 0, 0, 0, 0));
    send_item(make_item(OP_READ, 0, 0, 0, 1023));
    send_item(make_item(OP_RAISE, 0, 1023, 65535, 0));
    send_item(make_item(OP_READ, 0, 0, 0, 512));
    send_item(make_item(OP_LOWER, 5, 10, 0, 0));
    send_item(make_item(OP_READ, 0, 0, 0, 7));
    send_item(make_item(OP_READ, 0, 0, 0, 11));
    send_item(make_item(OP_RAISE, 10, 5, 12345, 0));   // first above last
    send_item(make_item(OP_READ, 0, 0, 0, 6));
    send_item(make_item(2'd3, 0, 1023, 1, 3));          // ignored op
    send_item(make_item(OP_LOWER, 1, 1022, 300, 0));
    send_item(make_item(OP_RAISE, 1023, 1023, 40000, 0));
    send_item(make_item(OP_READ, 0, 0, 0, 1023));
    send_item(make_item(OP_READ, 0, 0, 0, 1));
    drain();
    write_length(11'd1);
    send_item(make_item(OP_READ, 0, 0, 0, 1));          // beyond length
    send_item(make_item(OP_RAISE, 0, 1023, 500, 0));    // clipped range
    send_item(make_item(OP_RAISE, 1, 1023, 60000, 0));  // first not below length
    send_item(make_item(OP_READ, 0, 0, 0, 0));
    drain();
    write_length(11'd1024);
    send_item(make_item(OP_READ, 0, 0, 0, 1));          // untouched, shows again
    send_item(make_item(OP_READ, 0, 0, 0, 1023));

    // random phases over several lengths, extremes included
    lengths[0] = 11'd2047;
    lengths[1] = 11'd0;
    lengths[2] = 11'd513;
    lengths[3] = 11'd1;
    lengths[4] = 11'($urandom_range(1, 1024));
    lengths[5] = 11'd1024;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_length(lengths[ph]);
      cur_len = (lengths[ph] > 1024) ? 1024 : lengths[ph];
      for (int n = 0; n < 140; n++) begin
        if (ph == 2 && n == 20) begin
          hold_req = 1'b1;
        end
        send_item(rand_item(cur_len));
      end
    end

    stop_sending();
    @(posedge clk_i);
    while (pending_reads != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending_reads == 0) begin
      $display("range_clamp_segment_tree_tb: clean");
    end else begin
      $display("range_clamp_segment_tree_tb: errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("range_clamp_segment_tree_tb: errors");
    $finish;
  end
endmodule
